// ----- hw/rtl/dos_pkg.sv -----
// Shared types and constants for the depth-order sorter.
package dos_pkg;

    localparam int SLOT_W          = 6;
    localparam int KEY_W           = 24;
    localparam int COUNT_W         = 7;
    localparam int MAX_OBJECTS_DEF = 64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic signed [KEY_W-1:0] y_position;
        logic                    last_key;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] draw_slot;
        logic              last_slot;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REF_RD,
        ST_REF_KEY,
        ST_REF_WR,
        ST_SORT_RD,
        ST_SORT_LD,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        RD_P,
        RD_I,
        RD_IM1,
        RD_JM2
    } t_rd_sel;

    typedef struct packed {
        logic    in_take;
        logic    p_clr;
        logic    p_inc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    key_rd;
        logic    ref_wr;
        logic    mov_ld;
        logic    shift;
        logic    put;
        logic    i_set1;
        logic    i_inc;
        logic    out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic in_last;
        logic p_last;
        logic i_end;
        logic j_one;
        logic ge;
        logic unsorted;
        logic out_accept;
    } t_dp_stat;

endpackage

// ----- hw/rtl/depth_order_insertion_sort_core.sv -----
// Top level of the depth-order sorter: controller plus datapath.
//
// Input channel (i_valid / o_ready, payload i_data): one beat per slot key.
// A beat that is taken writes y_position into the key store.
// A beat with last_key set also starts the frame pass, during which o_ready
// stays low until the whole order has been sent.
// Output channel (o_valid / i_ready, payload o_data): n beats, one per draw
// position, last_slot set on the final one; n is object_count clamped to
// 1..MAX_OBJECTS.
// Frame pass: keys are refreshed into the order memory, then the order is
// emitted, one beat per draw position; the receiver can stall each beat.
// If the order is not already sorted, an insertion sort runs in between,
// with at most n(n-1)/2 position moves; its inner step does one read and
// one write of the order memory per cycle.
// Configuration: i_cfg_we writes object_count and returns the draw order to
// identity. Reset sets object_count to 64 and the order to identity; keys
// are undefined until loaded.
module depth_order_insertion_sort_core #(
    parameter int MAX_OBJECTS = dos_pkg::MAX_OBJECTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  dos_pkg::t_in_item           i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dos_pkg::t_out_item          o_data,
    input  logic                        i_cfg_we,
    input  logic [dos_pkg::COUNT_W-1:0] i_cfg_data
);

    dos_pkg::t_dp_cmd  cmd;
    dos_pkg::t_dp_stat stat;

    dos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    dos_datapath #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_ready    (i_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule

// ----- hw/rtl/dos_ctrl.sv -----
// Sequencer for refresh, insertion sort and emit passes of the depth-order sorter.
module dos_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dos_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output dos_pkg::t_dp_cmd  o_cmd
);

    dos_pkg::t_state r_state;
    dos_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dos_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dos_pkg::ST_IDLE: begin
                if (i_valid && i_stat.in_last) begin
                    n_state = dos_pkg::ST_REF_RD;
                end
            end
            dos_pkg::ST_REF_RD:  n_state = dos_pkg::ST_REF_KEY;
            dos_pkg::ST_REF_KEY: n_state = dos_pkg::ST_REF_WR;
            dos_pkg::ST_REF_WR: begin
                if (!i_stat.p_last) begin
                    n_state = dos_pkg::ST_REF_RD;
                end else if (i_stat.unsorted) begin
                    n_state = dos_pkg::ST_SORT_RD;
                end else begin
                    n_state = dos_pkg::ST_EMIT_RD;
                end
            end
            dos_pkg::ST_SORT_RD: n_state = dos_pkg::ST_SORT_LD;
            dos_pkg::ST_SORT_LD: n_state = dos_pkg::ST_SORT_CMP;
            dos_pkg::ST_SORT_CMP: begin
                if (i_stat.ge) begin
                    if (i_stat.j_one) begin
                        n_state = dos_pkg::ST_SORT_PUT;
                    end
                end else if (i_stat.i_end) begin
                    n_state = dos_pkg::ST_EMIT_RD;
                end else begin
                    n_state = dos_pkg::ST_SORT_RD;
                end
            end
            dos_pkg::ST_SORT_PUT: begin
                n_state = i_stat.i_end ? dos_pkg::ST_EMIT_RD : dos_pkg::ST_SORT_RD;
            end
            dos_pkg::ST_EMIT_RD: n_state = dos_pkg::ST_EMIT_LD;
            dos_pkg::ST_EMIT_LD: n_state = dos_pkg::ST_EMIT_WAIT;
            dos_pkg::ST_EMIT_WAIT: begin
                if (i_stat.out_accept) begin
                    n_state = i_stat.p_last ? dos_pkg::ST_IDLE : dos_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = dos_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            dos_pkg::ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.in_take = i_valid;
                o_cmd.p_clr   = i_valid && i_stat.in_last;
            end
            dos_pkg::ST_REF_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = dos_pkg::RD_P;
            end
            dos_pkg::ST_REF_KEY: begin
                o_cmd.key_rd = 1'b1;
            end
            dos_pkg::ST_REF_WR: begin
                o_cmd.ref_wr = 1'b1;
                o_cmd.p_inc  = !i_stat.p_last;
                o_cmd.p_clr  = i_stat.p_last;
                o_cmd.i_set1 = i_stat.p_last;
            end
            dos_pkg::ST_SORT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = dos_pkg::RD_I;
            end
            dos_pkg::ST_SORT_LD: begin
                o_cmd.mov_ld = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = dos_pkg::RD_IM1;
            end
            dos_pkg::ST_SORT_CMP: begin
                if (i_stat.ge) begin
                    // shift the earlier entry up one place, fetch the next one down
                    o_cmd.shift  = 1'b1;
                    o_cmd.rd_en  = !i_stat.j_one;
                    o_cmd.rd_sel = dos_pkg::RD_JM2;
                end else begin
                    o_cmd.put   = 1'b1;
                    o_cmd.i_inc = 1'b1;
                    o_cmd.p_clr = i_stat.i_end;
                end
            end
            dos_pkg::ST_SORT_PUT: begin
                o_cmd.put   = 1'b1;
                o_cmd.i_inc = 1'b1;
                o_cmd.p_clr = i_stat.i_end;
            end
            dos_pkg::ST_EMIT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = dos_pkg::RD_P;
            end
            dos_pkg::ST_EMIT_LD: begin
                o_cmd.out_ld = 1'b1;
            end
            dos_pkg::ST_EMIT_WAIT: begin
                o_cmd.p_inc = i_stat.out_accept && !i_stat.p_last;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/dos_datapath.sv -----
// Key store, draw-order memory, counters and output register of the depth-order sorter.
module dos_datapath #(
    parameter int MAX_OBJECTS = dos_pkg::MAX_OBJECTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dos_pkg::t_in_item              i_data,
    input  logic                           i_ready,
    input  logic                           i_cfg_we,
    input  logic [dos_pkg::COUNT_W-1:0]    i_cfg_data,
    input  dos_pkg::t_dp_cmd               i_cmd,
    output dos_pkg::t_dp_stat              o_stat,
    output logic                           o_valid,
    output dos_pkg::t_out_item             o_data
);

    localparam int IDXW = $clog2(MAX_OBJECTS);
    localparam int CNTW = $clog2(MAX_OBJECTS + 1);
    localparam int EW   = dos_pkg::KEY_W + IDXW;

    // order entry: {key, slot}
    logic [EW-1:0]                   ord_mem [MAX_OBJECTS];
    logic signed [dos_pkg::KEY_W-1:0] key_mem [MAX_OBJECTS];
    logic                            r_vld [MAX_OBJECTS];

    logic [dos_pkg::COUNT_W-1:0]     r_count;
    logic [EW-1:0]                   r_ord_q;
    logic                            r_ord_vq;
    logic [IDXW-1:0]                 r_rd_addr;
    logic signed [dos_pkg::KEY_W-1:0] r_key_q;
    logic [IDXW-1:0]                 r_slot_q;
    logic signed [dos_pkg::KEY_W-1:0] r_prev_key;
    logic                            r_unsorted;
    logic [CNTW-1:0]                 r_p;
    logic [CNTW-1:0]                 r_i;
    logic [CNTW-1:0]                 r_j;
    logic [EW-1:0]                   r_mov;
    dos_pkg::t_out_item              r_out;
    logic                            r_out_valid;

    logic [8:0]                      cnt9;
    logic [CNTW-1:0]                 n_used;
    logic [CNTW-1:0]                 nm1;
    logic [CNTW-1:0]                 rd_cnt;
    logic [IDXW-1:0]                 rd_addr;
    logic [IDXW-1:0]                 rd_slot;
    logic signed [dos_pkg::KEY_W-1:0] rd_key;
    logic signed [dos_pkg::KEY_W-1:0] mov_key;
    logic [8:0]                      in_slot9;
    logic                            in_slot_ok;
    logic [8:0]                      out_slot9;
    logic                            wr_en;
    logic [IDXW-1:0]                 wr_addr;
    logic [EW-1:0]                   wr_data;
    logic                            unsorted_now;
    logic                            out_accept;

    // count of zero means one slot, above the capacity saturates
    assign cnt9 = 9'(r_count);
    always_comb begin
        if (cnt9 == 9'd0) begin
            n_used = CNTW'(1);
        end else if (cnt9 > 9'(MAX_OBJECTS)) begin
            n_used = CNTW'(MAX_OBJECTS);
        end else begin
            n_used = CNTW'(cnt9);
        end
    end
    assign nm1 = n_used - CNTW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            dos_pkg::RD_P:   rd_cnt = r_p;
            dos_pkg::RD_I:   rd_cnt = r_i;
            dos_pkg::RD_IM1: rd_cnt = r_i - CNTW'(1);
            dos_pkg::RD_JM2: rd_cnt = r_j - CNTW'(2);
            default:         rd_cnt = r_p;
        endcase
    end
    assign rd_addr = rd_cnt[IDXW-1:0];

    // an entry never written since reset or a count write holds its own index
    assign rd_slot = r_ord_vq ? r_ord_q[IDXW-1:0] : r_rd_addr;
    assign rd_key  = r_ord_q[EW-1:IDXW];
    assign mov_key = r_mov[EW-1:IDXW];

    assign in_slot9   = 9'(i_data.slot);
    assign in_slot_ok = in_slot9 < 9'(MAX_OBJECTS);
    assign out_slot9  = 9'(rd_slot);

    assign wr_en   = i_cmd.ref_wr || i_cmd.shift || i_cmd.put;
    assign wr_addr = i_cmd.ref_wr ? r_p[IDXW-1:0] : r_j[IDXW-1:0];
    always_comb begin
        if (i_cmd.ref_wr) begin
            wr_data = {r_key_q, r_slot_q};
        end else if (i_cmd.shift) begin
            wr_data = {rd_key, rd_slot};
        end else begin
            wr_data = r_mov;
        end
    end

    assign unsorted_now = r_unsorted || ((r_p != '0) && (r_prev_key > r_key_q));
    assign out_accept   = r_out_valid && i_ready;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take && in_slot_ok) begin
            key_mem[in_slot9[IDXW-1:0]] <= i_data.y_position;
        end
        if (i_cmd.key_rd) begin
            r_key_q  <= key_mem[rd_slot];
            r_slot_q <= rd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ord_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_ord_q   <= ord_mem[rd_addr];
            r_ord_vq  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.mov_ld) begin
            r_mov <= {rd_key, rd_slot};
        end
        if (i_cmd.ref_wr) begin
            r_prev_key <= r_key_q;
        end
        if (i_cmd.out_ld) begin
            r_out.draw_slot <= out_slot9[dos_pkg::SLOT_W-1:0];
            r_out.last_slot <= (r_p == nm1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int k = 0; k < MAX_OBJECTS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= dos_pkg::COUNT_RESET;
            r_unsorted  <= 1'b0;
            r_p         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (i_cmd.p_clr) begin
                r_p        <= '0;
                r_unsorted <= 1'b0;
            end else begin
                if (i_cmd.p_inc) begin
                    r_p <= r_p + CNTW'(1);
                end
                if (i_cmd.ref_wr) begin
                    r_unsorted <= unsorted_now;
                end
            end
            if (i_cmd.i_set1) begin
                r_i <= CNTW'(1);
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + CNTW'(1);
            end
            if (i_cmd.mov_ld) begin
                r_j <= r_i;
            end else if (i_cmd.shift) begin
                r_j <= r_j - CNTW'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_last    = i_data.last_key;
    assign o_stat.p_last     = (r_p == nm1);
    assign o_stat.i_end      = (r_i == nm1);
    assign o_stat.j_one      = (r_j == CNTW'(1));
    assign o_stat.ge         = (rd_key >= mov_key);
    assign o_stat.unsorted   = unsorted_now;
    assign o_stat.out_accept = out_accept;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !i_cmd.in_take)
        else $error("input beat taken while a result beat is pending");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.ref_wr, i_cmd.shift, i_cmd.put}))
        else $error("conflicting writes to the order memory");

    a_shift_above_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_j != '0))
        else $error("shift below position zero");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && r_out.last_slot) |=> !r_out_valid)
        else $error("result beat after the last of the order");

endmodule

// ----- sim/depth_order_insertion_sort_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for the depth-order sorter: key loads, frame sorts and draw-order checks.
module depth_order_insertion_sort_core_test;

    localparam int MAX_OBJ     = dos_pkg::MAX_OBJECTS_DEF;
    localparam int KW          = dos_pkg::KEY_W;
    localparam int SW          = dos_pkg::SLOT_W;
    localparam int CW          = dos_pkg::COUNT_W;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_EXTREME,
        KEYS_REPEAT,
        KEYS_RISING
    } t_key_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    dos_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_ready;
    dos_pkg::t_out_item o_data;
    logic               i_cfg_we;
    logic [CW-1:0]      i_cfg_data;

    // predictor state
    logic signed [KW-1:0]  key_mem [0:MAX_OBJ-1];
    bit                    key_loaded [0:MAX_OBJ-1];
    logic [SW-1:0]         order_mem [0:MAX_OBJ-1];
    logic [CW-1:0]         count_reg;
    dos_pkg::t_out_item    expected_draw [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_len  = 0;
    int beats_sent   = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    depth_order_insertion_sort_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL depth_order_insertion_sort_core");
            $finish;
        end
    end

    function automatic int active_slots();
        if (count_reg == '0) return 1;
        if (count_reg > MAX_OBJ) return MAX_OBJ;
        return int'(count_reg);
    endfunction

    function automatic void reset_draw_order();
        for (int i = 0; i < MAX_OBJ; i++) order_mem[i] = SW'(i);
    endfunction

    function automatic void sort_draw_order(input int n);
        int i, j;
        bit ordered;
        logic [SW-1:0] moving;
        logic signed [KW-1:0] k;
        ordered = 1'b1;
        for (i = 0; i + 1 < n; i++)
            if (key_mem[order_mem[i]] > key_mem[order_mem[i+1]]) ordered = 1'b0;
        // an already ordered list is kept as is, ties included
        if (ordered) return;
        for (i = 1; i < n; i++) begin
            moving = order_mem[i];
            k = key_mem[moving];
            j = i;
            while (j > 0 && key_mem[order_mem[j-1]] >= k) begin
                order_mem[j] = order_mem[j-1];
                j--;
            end
            order_mem[j] = moving;
        end
    endfunction

    function automatic void predict_key_beat(input dos_pkg::t_in_item beat);
        int n;
        dos_pkg::t_out_item r;
        key_mem[beat.slot] = beat.y_position;
        key_loaded[beat.slot] = 1'b1;
        if (!beat.last_key) return;
        n = active_slots();
        sort_draw_order(n);
        for (int i = 0; i < n; i++) begin
            r.draw_slot = order_mem[i];
            r.last_slot = (i == n - 1);
            expected_draw.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(input string what, input int want, input int got);
        if (err_cnt < 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        err_cnt++;
    endfunction

    // output side: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                hold_left = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_draw_order
        dos_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_draw.size() == 0) begin
                report_mismatch("unexpected beat, draw_slot", -1, int'(o_data.draw_slot));
            end else begin
                want = expected_draw.pop_front();
                if (o_data.draw_slot !== want.draw_slot)
                    report_mismatch("draw_slot", int'(want.draw_slot), int'(o_data.draw_slot));
                if (o_data.last_slot !== want.last_slot)
                    report_mismatch("last_slot", int'(want.last_slot), int'(o_data.last_slot));
            end
        end
    end

    task automatic send_beat(input dos_pkg::t_in_item beat);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_key_beat(beat);
        beats_sent++;
    endtask

    task automatic load_key(input int slot, input logic signed [KW-1:0] y, input bit last);
        dos_pkg::t_in_item beat;
        beat.slot       = SW'(slot);
        beat.y_position = y;
        beat.last_key   = last;
        send_beat(beat);
    endtask

    // drop valid, drain every expected beat, then let the block settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_draw.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CW-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        count_reg = value;
        reset_draw_order();
    endtask

    function automatic logic signed [KW-1:0] pick_key(input t_key_mix mix, input int slot);
        logic [31:0] bits;
        logic signed [KW-1:0] v;
        bits = $urandom;
        case (mix)
            KEYS_NARROW: begin
                v = {{(KW-2){bits[1]}}, bits[1:0]};
            end
            KEYS_EXTREME: begin
                case (bits[1:0])
                    2'd0: v = {1'b1, {(KW-1){1'b0}}};
                    2'd1: v = {1'b0, {(KW-1){1'b1}}};
                    2'd2: v = '0;
                    default: v = '1;
                endcase
            end
            KEYS_REPEAT: begin
                v = key_loaded[slot] ? key_mem[slot] : bits[KW-1:0];
            end
            KEYS_RISING: begin
                v = KW'(slot * 1000 - 20000);
            end
            default: begin
                v = bits[KW-1:0];
            end
        endcase
        return v;
    endfunction

    // one frame: keys for the active slots (all or a subset), optional stray
    // keys, shuffled; the final beat carries the last mark
    task automatic send_frame(input t_key_mix mix, input bit full_set, input int stray);
        int picks[$];
        int n, i, r, tmp;
        dos_pkg::t_in_item beat;
        n = active_slots();
        for (i = 0; i < n; i++)
            if (full_set || !key_loaded[i] || $urandom_range(1)) picks.push_back(i);
        for (i = 0; i < stray; i++) picks.push_back($urandom_range(MAX_OBJ - 1));
        if (picks.size() == 0) picks.push_back($urandom_range(MAX_OBJ - 1));
        for (i = picks.size() - 1; i > 0; i--) begin
            r = $urandom_range(i);
            tmp = picks[i];
            picks[i] = picks[r];
            picks[r] = tmp;
        end
        for (i = 0; i < picks.size(); i++) begin
            beat.slot       = SW'(picks[i]);
            beat.y_position = pick_key(mix, picks[i]);
            beat.last_key   = (i == picks.size() - 1);
            send_beat(beat);
        end
    endtask

    function automatic logic [CW-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return CW'($urandom_range(12, 1));
        if (roll < 85) return CW'($urandom_range(MAX_OBJ, 13));
        if (roll < 92) return CW'($urandom_range(127, MAX_OBJ + 1));
        if (roll < 96) return '0;
        return CW'(MAX_OBJ);
    endfunction

    // full frame under the reset count, loading every slot
    task automatic t_reset_count_frame();
        send_frame(KEYS_WIDE, 1'b1, 0);
        wait_idle();
    endtask

    task automatic t_directed_cases();
        logic signed [KW-1:0] kmin, kmax;
        kmin = {1'b1, {(KW-1){1'b0}}};
        kmax = {1'b0, {(KW-1){1'b1}}};
        write_count(CW'(1));
        load_key(0, kmax, 1'b1);
        // zero count acts as a single slot; a key without the mark yields nothing
        write_count('0);
        load_key(63, kmin, 1'b0);
        load_key(0, kmin, 1'b1);
        // counts above the slot range saturate
        write_count('1);
        load_key(63, '0, 1'b1);
        write_count(CW'(MAX_OBJ + 1));
        load_key(5, '1, 1'b1);
        // equal keys already in order are kept, then reversed by a real sort
        write_count(CW'(4));
        for (int s = 0; s < 4; s++) load_key(s, KW'(256), s == 3);
        load_key(0, kmax, 1'b1);
        // strictly descending keys
        load_key(0, kmax, 1'b0);
        load_key(1, KW'(1), 1'b0);
        load_key(2, '0, 1'b0);
        load_key(3, kmin, 1'b1);
        // key for a slot outside the count is held until the count covers it
        load_key(40, kmin, 1'b1);
        write_count(CW'(41));
        load_key(0, '0, 1'b1);
        write_count(CW'(MAX_OBJ));
        load_key(1, kmax, 1'b1);
        wait_idle();
    endtask

    task automatic t_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_count(CW'(8));
        // hold the output while frames keep coming so the input stalls
        rx_hold_len = HOLD_CYCLES;
        for (int f = 0; f < 3; f++) send_frame(KEYS_WIDE, 1'b1, 1);
        wait_idle();
        // sender waits for every result before the next frame
        for (int f = 0; f < 2; f++) begin
            send_frame(KEYS_NARROW, 1'b1, 0);
            wait_idle();
        end
    endtask

    task automatic t_random_traffic(input int tx_pct, input int rx_pct, input int beat_goal);
        int stop_at, frames;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at = beats_sent + beat_goal;
        while (beats_sent < stop_at) begin
            write_count(pick_count());
            frames = $urandom_range(4, 1);
            for (int f = 0; f < frames; f++)
                send_frame(t_key_mix'($urandom_range(int'(KEYS_RISING))),
                           $urandom_range(9) < 8,
                           ($urandom_range(2) == 0) ? $urandom_range(3) : 0);
        end
        wait_idle();
    endtask

    initial begin
        int drain_wait;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        count_reg  = dos_pkg::COUNT_RESET;
        reset_draw_order();
        for (int i = 0; i < MAX_OBJ; i++) key_loaded[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        t_reset_count_frame();
        t_directed_cases();
        t_output_backpressure();
        t_random_traffic(0, 0, 60);
        t_random_traffic(63, 0, 60);
        t_random_traffic(0, 63, 60);
        t_random_traffic(30, 30, 60);

        drain_wait = 0;
        while (expected_draw.size() != 0 && drain_wait < 100_000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_draw.size() != 0)
            report_mismatch("beats never delivered", expected_draw.size(), 0);

        if (err_cnt == 0) begin
            $display("PASS depth_order_insertion_sort_core");
        end else begin
            $display("FAIL depth_order_insertion_sort_core");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dos_pkg.sv
hw/rtl/dos_ctrl.sv
hw/rtl/dos_datapath.sv
hw/rtl/depth_order_insertion_sort_core.sv
sim/depth_order_insertion_sort_core_test.sv
